@@ src/linear_regression_gradient_step_defines.svh @@
// Assertion macros used by the gradient step back end.
`ifndef LINEAR_REGRESSION_GRADIENT_STEP_DEFINES_SVH
`define LINEAR_REGRESSION_GRADIENT_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/lrgs_pkg.sv @@
// Types and constants for the linear regression gradient step block.
package lrgs_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int PROD_W      = 80;
  localparam int DIV_CNT_W   = $clog2(PROD_W);
  localparam logic [15:0] STEP_RESET = 16'd655;
  localparam logic [40:0] MAG_CAP    = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_point;
  } lrgs_in_t;

  typedef struct packed {
    logic signed [31:0] new_weight;
    logic signed [31:0] new_bias;
    logic               pass_overflow;
  } lrgs_out_t;

  // One queued word: the sample plus what the front made of it.
  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_point;
    logic               drop;
    logic               ovf;
    logic [CNT_W-1:0]   n;
  } lrgs_item_t;

endpackage

@@ src/lrgs_front.sv @@
// Front end: counts points of a pass and marks dropped words and overflow.
module lrgs_front import lrgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lrgs_in_t   in_data,
  output logic       q_valid,
  input  logic       q_ready,
  output lrgs_item_t q_item
);

  logic [CNT_W-1:0] count;
  logic             ovf_seen;
  logic             drop;
  logic [CNT_W-1:0] count_next;

  assign drop       = (count == CNT_W'(MAX_POINTS));
  assign count_next = drop ? count : count + 1'b1;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;

  always_comb begin
    q_item.sample_x   = in_data.sample_x;
    q_item.sample_y   = in_data.sample_y;
    q_item.last_point = in_data.last_point;
    q_item.drop       = drop;
    q_item.ovf        = ovf_seen | drop;
    q_item.n          = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (in_valid && q_ready) begin
      if (in_data.last_point) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end else begin
        count    <= count_next;
        ovf_seen <= ovf_seen | drop;
      end
    end
  end

endmodule

@@ src/lrgs_queue.sv @@
// Short register queue between the front end and the arithmetic back end.
module lrgs_queue import lrgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  lrgs_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output lrgs_item_t pop_item
);

  lrgs_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   cnt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ src/lrgs_back.sv @@
// Back end: residual and gradient accumulation, end-of-pass update with serial divide.
`include "linear_regression_gradient_step_defines.svh"
module lrgs_back import lrgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  lrgs_item_t  q_item,
  input  logic [15:0] step_size,
  output logic        out_valid,
  input  logic        out_ready,
  output lrgs_out_t   out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_ACCUM, S_UMUL, S_USUM, S_DIV, S_APPLY, S_EMIT
  } state_t;

  localparam logic signed [41:0] V_MAX = 42'sd2147483647;
  localparam logic signed [41:0] V_MIN = -42'sd2147483648;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  state_t              state;
  logic signed [31:0]  weight;
  logic signed [31:0]  bias;
  logic signed [63:0]  wsum;
  logic signed [63:0]  bsum;
  logic signed [15:0]  cur_x;
  logic signed [15:0]  cur_y;
  logic                cur_last;
  logic                cur_ovf;
  logic [CNT_W-1:0]    cur_n;
  logic signed [47:0]  wx;
  logic signed [40:0]  r16;
  logic signed [56:0]  prod;
  logic                sel;
  logic                neg;
  logic [47:0]         hi;
  logic [47:0]         lo;
  logic [PROD_W-1:0]   quo;
  logic [CNT_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] bitcnt;
  logic signed [31:0]  nw;
  logic signed [31:0]  nb;
  logic                emit_fire;

  // per-point datapath
  logic signed [47:0]  wx_c;
  logic signed [48:0]  r24_c;
  logic signed [40:0]  r16_c;
  logic signed [56:0]  prod_c;
  logic signed [58:0]  n2_c;
  logic signed [50:0]  gw_c;
  logic signed [42:0]  gb_c;

  assign wx_c   = weight * q_item.sample_x;
  assign r24_c  = (49'(cur_y) <<< 16) - 49'(wx) - (49'(bias) <<< 8);
  assign r16_c  = r24_c[48:8];
  assign prod_c = cur_x * r16_c;
  assign n2_c   = 59'sd0 - (59'(prod) <<< 1);
  assign gw_c   = n2_c[58:8];
  assign gb_c   = 43'sd0 - (43'(r16) <<< 1);

  // update datapath
  logic signed [63:0]  sum_sel;
  logic [63:0]         mag_c;
  logic [CNT_W:0]      trial_c;
  logic                ge_c;
  logic [CNT_W-1:0]    rem_c;
  logic                cap_c;
  logic [40:0]         d_c;
  logic signed [31:0]  cur_sel;
  logic signed [41:0]  v_c;
  logic signed [31:0]  sat_c;

  assign sum_sel = sel ? bsum : wsum;
  assign mag_c   = sum_sel[63] ? (64'd0 - sum_sel) : sum_sel;
  assign trial_c = {rem, quo[PROD_W-1]};
  assign ge_c    = (trial_c >= {1'b0, cur_n});
  assign rem_c   = ge_c ? CNT_W'(trial_c - {1'b0, cur_n}) : trial_c[CNT_W-1:0];

  // magnitude is quotient / 2^16, capped at 2^40
  assign cap_c   = (|quo[PROD_W-1:57]) || (quo[56:16] > MAG_CAP);
  assign d_c     = cap_c ? MAG_CAP : quo[56:16];
  assign cur_sel = sel ? bias : weight;
  assign v_c     = neg ? (42'(cur_sel) + $signed({1'b0, d_c}))
                       : (42'(cur_sel) - $signed({1'b0, d_c}));

  always_comb begin
    if (v_c > V_MAX) begin
      sat_c = V_MAX[31:0];
    end else if (v_c < V_MIN) begin
      sat_c = V_MIN[31:0];
    end else begin
      sat_c = v_c[31:0];
    end
  end

  assign q_ready   = (state == S_IDLE);
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      weight    <= '0;
      bias      <= '0;
      wsum      <= '0;
      bsum      <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_EMIT the output register is reloaded below
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_x    <= q_item.sample_x;
            cur_y    <= q_item.sample_y;
            cur_last <= q_item.last_point;
            cur_ovf  <= q_item.ovf;
            cur_n    <= q_item.n;
            wx       <= wx_c;
            if (!q_item.drop) begin
              state <= S_PROD;
            end else if (q_item.last_point) begin
              nw    <= weight;
              nb    <= bias;
              state <= S_EMIT;
            end
          end
        end
        S_PROD: begin
          r16   <= r16_c;
          prod  <= prod_c;
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          wsum <= sat_add(wsum, 64'(gw_c));
          bsum <= sat_add(bsum, 64'(gb_c));
          if (!cur_last) begin
            state <= S_IDLE;
          end else if (cur_ovf) begin
            nw    <= weight;
            nb    <= bias;
            state <= S_EMIT;
          end else begin
            sel   <= 1'b0;
            state <= S_UMUL;
          end
        end
        S_UMUL: begin
          neg   <= sum_sel[63];
          hi    <= mag_c[63:32] * step_size;
          lo    <= mag_c[31:0] * step_size;
          state <= S_USUM;
        end
        S_USUM: begin
          quo    <= {hi, 32'd0} + PROD_W'(lo);
          rem    <= '0;
          bitcnt <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          rem    <= rem_c;
          quo    <= {quo[PROD_W-2:0], ge_c};
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == DIV_CNT_W'(PROD_W - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!sel) begin
            nw    <= sat_c;
            sel   <= 1'b1;
            state <= S_UMUL;
          end else begin
            nb    <= sat_c;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.new_weight    <= nw;
            out_data.new_bias      <= nb;
            out_data.pass_overflow <= cur_ovf;
            weight                 <= nw;
            bias                   <= nb;
            wsum                   <= '0;
            bsum                   <= '0;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_div_rem_below_n, state == S_DIV, rem < cur_n)
  `ASSERT_NEXT(a_emit_waits, state == S_EMIT && out_valid && !out_ready, state == S_EMIT)
  `ASSERT_NEXT(a_ovf_keeps_state, emit_fire && cur_ovf,
               out_valid && out_data.pass_overflow && out_data.new_weight == weight
               && out_data.new_bias == bias)
  `ASSERT_NEXT(a_sums_cleared, emit_fire, wsum == 64'sd0 && bsum == 64'sd0)

endmodule

@@ src/linear_regression_gradient_step.sv @@
// Top level of the linear regression batch gradient-descent step.
// Input channel (in_valid/in_ready/in_data): one (x, y) sample per word, Q8.8, with
// last_point set on the final sample of a pass. Words go into a four-entry queue,
// so the source keeps sending while the arithmetic is busy.
// In the back end each sample goes through weight*x, x*residual and accumulate;
// the queue is filled at one word per cycle until it is full.
// The last sample triggers the update of weight and bias: per value one
// 64x16 product and a one-bit-per-cycle divide by the point count, then
// the result word is written to the output register.
// Output channel (out_valid/out_ready/out_data): one word per pass, held in an
// output register. While it is not taken the back end works on into the next
// pass and then waits holding the next result; the queue fills and in_ready drops.
// Passes longer than MAX_POINTS drop the extra samples and report pass_overflow
// with weight and bias unchanged.
// cfg_valid/cfg_data write the Q0.16 step size; always ready, reset value 655.
// Synchronous reset clears weight, bias, sums, counters, queue and output.
module linear_regression_gradient_step import lrgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lrgs_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lrgs_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] step_size;
  logic        f_valid;
  logic        f_ready;
  lrgs_item_t  f_item;
  logic        b_valid;
  logic        b_ready;
  lrgs_item_t  b_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RESET;
    end else if (cfg_valid) begin
      step_size <= cfg_data;
    end
  end

  lrgs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  lrgs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  lrgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_item    (b_item),
    .step_size (step_size),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
